### design/assert_macros.svh
// assertion macros used by the gain pipeline core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### design/wbg_pkg.sv
// constants of the white balance gain pipeline
`timescale 1ns / 1ps
`default_nettype none
package wbg_pkg;
   localparam int unsigned GAIN_SCALE    = 1000;
   localparam int unsigned UNITY_GAIN    = 1024;
   localparam int unsigned GOLDEN_OFFSET = 512;
   localparam int unsigned DIV1_STEPS    = 20;
   localparam int unsigned DIV2_STEPS    = 16;
   localparam int unsigned LATENCY       = 42;
   localparam int unsigned LANES         = 3;

   // register indexes
   localparam logic [1:0] REG_RG_TYPICAL = 2'd0;
   localparam logic [1:0] REG_BG_TYPICAL = 2'd1;
   localparam logic [1:0] REG_GOLDEN_RG  = 2'd2;
   localparam logic [1:0] REG_GOLDEN_BG  = 2'd3;
endpackage
`default_nettype wire

### design/otp_white_balance_gain_core.sv
// white balance gain pipeline top level
//
// Usage: drive a calibration record on the req_ ports and pulse start; the
// block is never busy, so a record is taken at every clock edge with start
// high. The record flows through a 42 stage pipeline: join and golden
// multiply, ratio and numerator, a 20 step restoring divider (typical*1000 /
// ratio, two lanes), base selection, a saturation check, then a 16 step
// divider with three lanes (0x400*gain / base). Each record gives one beat on
// the rsp_ ports, marked by rsp_valid for one cycle. Throughput is one record
// per clock, set by the one-bit-per-stage divider chains. The receiver cannot
// stall; the pipeline always advances.
// Configuration (csr_) is written whenever csr_write_enable is high and
// should change only while no records are in flight. Synchronous reset
// clears the pipeline valid bits and restores the register defaults
// (typical ratios 256, golden flags off). A zero ratio or zero base sets
// rsp_divide_error and forces all gains and write flags to zero.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module otp_white_balance_gain_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [7:0]  req_rg_high_byte,
   input  wire logic [7:0]  req_bg_high_byte,
   input  wire logic [7:0]  req_rg_adjust_high_byte,
   input  wire logic [7:0]  req_bg_adjust_high_byte,
   input  wire logic [7:0]  req_low_bits_byte,
   output logic             rsp_valid,
   output logic [15:0]      rsp_red_gain,
   output logic [15:0]      rsp_green_gain,
   output logic [15:0]      rsp_blue_gain,
   output logic             rsp_red_write,
   output logic             rsp_green_write,
   output logic             rsp_blue_write,
   output logic             rsp_divide_error,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire logic [9:0]  csr_write_data
);
   localparam int unsigned D1 = wbg_pkg::DIV1_STEPS;
   localparam int unsigned D2 = wbg_pkg::DIV2_STEPS;
   localparam int unsigned NL = wbg_pkg::LANES;

   // configuration registers
   logic [9:0] rg_typical_ff, bg_typical_ff;
   logic       golden_rg_ff, golden_bg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rg_typical_ff <= 10'd256;
         bg_typical_ff <= 10'd256;
         golden_rg_ff  <= 1'b0;
         golden_bg_ff  <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            wbg_pkg::REG_RG_TYPICAL: rg_typical_ff <= csr_write_data;
            wbg_pkg::REG_BG_TYPICAL: bg_typical_ff <= csr_write_data;
            wbg_pkg::REG_GOLDEN_RG:  golden_rg_ff  <= csr_write_data[0];
            wbg_pkg::REG_GOLDEN_BG:  golden_bg_ff  <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   // stage 0: join the 10 bit fields
   logic       v0_ff;
   logic [9:0] rg_ff, bg_ff, rgadj_ff, bgadj_ff;

   always_ff @(posedge clock) begin
      if (reset) v0_ff <= 1'b0;
      else       v0_ff <= start;
   end

   always_ff @(posedge clock) begin
      rg_ff    <= {req_rg_high_byte, req_low_bits_byte[7:6]};
      bg_ff    <= {req_bg_high_byte, req_low_bits_byte[5:4]};
      rgadj_ff <= {req_rg_adjust_high_byte, req_low_bits_byte[3:2]};
      bgadj_ff <= {req_bg_adjust_high_byte, req_low_bits_byte[1:0]};
   end

   // stage 1: golden scaling product
   logic        v1_ff;
   logic [20:0] prod_r_ff, prod_b_ff, prod_r_in, prod_b_in;

   always_comb begin
      prod_r_in = golden_rg_ff
         ? 21'(rg_ff) * (21'(rgadj_ff) + 21'(wbg_pkg::GOLDEN_OFFSET))
         : {1'b0, rg_ff, 10'd0};
      prod_b_in = golden_bg_ff
         ? 21'(bg_ff) * (21'(bgadj_ff) + 21'(wbg_pkg::GOLDEN_OFFSET))
         : {1'b0, bg_ff, 10'd0};
   end

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else       v1_ff <= v0_ff;
   end

   always_ff @(posedge clock) begin
      prod_r_ff <= prod_r_in;
      prod_b_ff <= prod_b_in;
   end

   // first divider: typical*1000 / ratio, one quotient bit per stage
   logic        d1_v_ff   [0:D1];
   logic        d1_err_ff [0:D1];
   logic [10:0] d1_rem_ff [0:D1][0:1];
   logic [19:0] d1_num_ff [0:D1][0:1];
   logic [10:0] d1_div_ff [0:D1][0:1];

   // stage 2: ratios, numerators and zero ratio check
   always_ff @(posedge clock) begin
      if (reset) d1_v_ff[0] <= 1'b0;
      else       d1_v_ff[0] <= v1_ff;
   end

   always_ff @(posedge clock) begin
      d1_div_ff[0][0] <= prod_r_ff[20:10];
      d1_div_ff[0][1] <= prod_b_ff[20:10];
      d1_rem_ff[0][0] <= 11'd0;
      d1_rem_ff[0][1] <= 11'd0;
      d1_num_ff[0][0] <= 20'(rg_typical_ff) * 20'(wbg_pkg::GAIN_SCALE);
      d1_num_ff[0][1] <= 20'(bg_typical_ff) * 20'(wbg_pkg::GAIN_SCALE);
      d1_err_ff[0]    <= (prod_r_ff[20:10] == 11'd0) || (prod_b_ff[20:10] == 11'd0);
   end

   for (genvar k = 0; k < D1; k++) begin : g_div1
      always_ff @(posedge clock) begin
         if (reset) d1_v_ff[k+1] <= 1'b0;
         else       d1_v_ff[k+1] <= d1_v_ff[k];
      end
      always_ff @(posedge clock) begin
         d1_err_ff[k+1] <= d1_err_ff[k];
      end
      for (genvar l = 0; l < 2; l++) begin : g_lane
         logic [11:0] trial_in, diff_in;
         logic        ge_in;
         always_comb begin
            trial_in = {d1_rem_ff[k][l], d1_num_ff[k][l][19]};
            diff_in  = trial_in - {1'b0, d1_div_ff[k][l]};
            ge_in    = trial_in >= {1'b0, d1_div_ff[k][l]};
         end
         always_ff @(posedge clock) begin
            d1_div_ff[k+1][l] <= d1_div_ff[k][l];
            d1_rem_ff[k+1][l] <= ge_in ? diff_in[10:0] : trial_in[10:0];
            d1_num_ff[k+1][l] <= {d1_num_ff[k][l][18:0], ge_in};
         end
      end
   end

   // base selection
   logic        bs_v_ff, bs_err_ff;
   logic [19:0] bs_rgain_ff, bs_bgain_ff;
   logic [9:0]  bs_base_ff, base_in;
   logic [19:0] qr, qb, min_in;
   logic        below_in;

   always_comb begin
      qr       = d1_num_ff[D1][0];
      qb       = d1_num_ff[D1][1];
      below_in = (qr < 20'(wbg_pkg::GAIN_SCALE)) || (qb < 20'(wbg_pkg::GAIN_SCALE));
      min_in   = (qr < qb) ? qr : qb;
      base_in  = below_in ? min_in[9:0] : 10'(wbg_pkg::GAIN_SCALE);
   end

   always_ff @(posedge clock) begin
      if (reset) bs_v_ff <= 1'b0;
      else       bs_v_ff <= d1_v_ff[D1];
   end

   always_ff @(posedge clock) begin
      bs_rgain_ff <= qr;
      bs_bgain_ff <= qb;
      bs_base_ff  <= base_in;
      bs_err_ff   <= d1_err_ff[D1] || (base_in == 10'd0);
   end

   // second divider: 0x400*gain / base, saturation found up front
   logic        d2_v_ff   [0:D2];
   logic        d2_err_ff [0:D2];
   logic [9:0]  d2_base_ff[0:D2];
   logic [9:0]  d2_rem_ff [0:D2][0:NL-1];
   logic [15:0] d2_num_ff [0:D2][0:NL-1];
   logic        d2_sat_ff [0:D2][0:NL-1];
   logic [29:0] n_in [0:NL-1];

   always_comb begin
      n_in[0] = {bs_rgain_ff, 10'd0};
      n_in[1] = {20'(wbg_pkg::GAIN_SCALE), 10'd0};
      n_in[2] = {bs_bgain_ff, 10'd0};
   end

   always_ff @(posedge clock) begin
      if (reset) d2_v_ff[0] <= 1'b0;
      else       d2_v_ff[0] <= bs_v_ff;
   end

   always_ff @(posedge clock) begin
      d2_err_ff[0]  <= bs_err_ff;
      d2_base_ff[0] <= bs_base_ff;
   end

   for (genvar l = 0; l < NL; l++) begin : g_sat
      always_ff @(posedge clock) begin
         d2_sat_ff[0][l] <= n_in[l][29:16] >= {4'd0, bs_base_ff};
         d2_rem_ff[0][l] <= n_in[l][25:16];
         d2_num_ff[0][l] <= n_in[l][15:0];
      end
   end

   for (genvar k = 0; k < D2; k++) begin : g_div2
      always_ff @(posedge clock) begin
         if (reset) d2_v_ff[k+1] <= 1'b0;
         else       d2_v_ff[k+1] <= d2_v_ff[k];
      end
      always_ff @(posedge clock) begin
         d2_err_ff[k+1]  <= d2_err_ff[k];
         d2_base_ff[k+1] <= d2_base_ff[k];
      end
      for (genvar l = 0; l < NL; l++) begin : g_lane
         logic [10:0] trial_in, diff_in;
         logic        ge_in;
         always_comb begin
            trial_in = {d2_rem_ff[k][l], d2_num_ff[k][l][15]};
            diff_in  = trial_in - {1'b0, d2_base_ff[k]};
            ge_in    = trial_in >= {1'b0, d2_base_ff[k]};
         end
         always_ff @(posedge clock) begin
            d2_sat_ff[k+1][l] <= d2_sat_ff[k][l];
            d2_rem_ff[k+1][l] <= ge_in ? diff_in[9:0] : trial_in[9:0];
            d2_num_ff[k+1][l] <= {d2_num_ff[k][l][14:0], ge_in};
         end
      end
   end

   // output beat: saturate, flag and clear on error
   logic [15:0] gain_in [0:NL-1];
   logic        err_out;

   always_comb begin
      err_out = d2_err_ff[D2];
      for (int l = 0; l < NL; l++) begin
         gain_in[l] = err_out ? 16'd0
                    : (d2_sat_ff[D2][l] ? 16'hFFFF : d2_num_ff[D2][l]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else       rsp_valid <= d2_v_ff[D2];
   end

   always_ff @(posedge clock) begin
      rsp_red_gain     <= gain_in[0];
      rsp_green_gain   <= gain_in[1];
      rsp_blue_gain    <= gain_in[2];
      rsp_red_write    <= gain_in[0] > 16'(wbg_pkg::UNITY_GAIN);
      rsp_green_write  <= gain_in[1] > 16'(wbg_pkg::UNITY_GAIN);
      rsp_blue_write   <= gain_in[2] > 16'(wbg_pkg::UNITY_GAIN);
      rsp_divide_error <= err_out;
   end

   // checks
   `ASSERT_IMPLIES(a_latency, clock, reset, start, ##42 rsp_valid)
   `ASSERT_IMPLIES(a_err_zero, clock, reset, rsp_valid && rsp_divide_error,
      rsp_red_gain == 16'd0 && rsp_green_gain == 16'd0 && rsp_blue_gain == 16'd0)
   `ASSERT_IMPLIES(a_green_floor, clock, reset, rsp_valid && !rsp_divide_error,
      rsp_green_gain >= 16'h400)
   `ASSERT_NEXT(a_base_range, clock, reset, d1_v_ff[D1] && !d1_err_ff[D1],
      bs_err_ff || (bs_base_ff != 10'd0 && bs_base_ff <= 10'd1000))
endmodule
`default_nettype wire

### sim/otp_white_balance_gain_core_test.sv
// self-checking testbench for the white balance gain pipeline
`timescale 1ns / 1ps
`default_nettype none
module otp_white_balance_gain_core_test;

   typedef struct packed {
      logic [15:0] red_gain;
      logic [15:0] green_gain;
      logic [15:0] blue_gain;
      logic        red_write;
      logic        green_write;
      logic        blue_write;
      logic        divide_error;
   } gains_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [7:0]  req_rg_high_byte = '0;
   logic [7:0]  req_bg_high_byte = '0;
   logic [7:0]  req_rg_adjust_high_byte = '0;
   logic [7:0]  req_bg_adjust_high_byte = '0;
   logic [7:0]  req_low_bits_byte = '0;
   logic        rsp_valid;
   logic [15:0] rsp_red_gain;
   logic [15:0] rsp_green_gain;
   logic [15:0] rsp_blue_gain;
   logic        rsp_red_write;
   logic        rsp_green_write;
   logic        rsp_blue_write;
   logic        rsp_divide_error;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [9:0]  csr_write_data = '0;

   // shadow copy of the registers
   logic [9:0] rg_typ_q;
   logic [9:0] bg_typ_q;
   logic       golden_rg_q;
   logic       golden_bg_q;

   gains_type  pending_gains[$];
   int         errors = 0;
   int         records_sent = 0;
   int         beats_checked = 0;
   int         error_beats = 0;
   longint     cycles = 0;

   otp_white_balance_gain_core dut (.*);

   always #5 clock = ~clock;

   // generous run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("FAIL otp_white_balance_gain_core");
         $finish;
      end
   end

   // gain of one channel, saturated
   function automatic logic [15:0] channel_gain(logic [63:0] g, logic [63:0] base);
      logic [63:0] v;
      v = (64'd1024 * g) / base;
      return (v > 64'd65535) ? 16'hFFFF : v[15:0];
   endfunction

   // expected gains for one calibration record
   function automatic gains_type compute_gains(logic [7:0] rgh, logic [7:0] bgh,
         logic [7:0] rah, logic [7:0] bah, logic [7:0] low);
      gains_type   res;
      logic [63:0] rg, bg, ra, ba, rgain, bgain, base;
      res = '0;
      rg = 64'({rgh, low[7:6]});
      bg = 64'({bgh, low[5:4]});
      ra = 64'({rah, low[3:2]});
      ba = 64'({bah, low[1:0]});
      if (golden_rg_q) rg = (rg * (ra + 64'd512)) / 64'd1024;
      if (golden_bg_q) bg = (bg * (ba + 64'd512)) / 64'd1024;
      if (rg == 0 || bg == 0) begin
         res.divide_error = 1'b1;
         return res;
      end
      rgain = (64'(rg_typ_q) * 64'd1000) / rg;
      bgain = (64'(bg_typ_q) * 64'd1000) / bg;
      if (rgain < 1000 || bgain < 1000) base = (rgain < bgain) ? rgain : bgain;
      else base = 64'd1000;
      if (base == 0) begin
         res.divide_error = 1'b1;
         return res;
      end
      res.red_gain = channel_gain(rgain, base);
      res.green_gain = channel_gain(64'd1000, base);
      res.blue_gain = channel_gain(bgain, base);
      res.red_write = res.red_gain > 16'h400;
      res.green_write = res.green_gain > 16'h400;
      res.blue_write = res.blue_gain > 16'h400;
      return res;
   endfunction

   // compare each result beat with the oldest expectation
   always @(posedge clock) begin
      gains_type exp_g, got;
      if (!reset && rsp_valid) begin
         got = {rsp_red_gain, rsp_green_gain, rsp_blue_gain, rsp_red_write,
                rsp_green_write, rsp_blue_write, rsp_divide_error};
         if (pending_gains.size() == 0) begin
            $display("%0t unexpected beat: actual %h", $time, got);
            errors++;
         end else begin
            exp_g = pending_gains.pop_front();
            beats_checked++;
            if (exp_g.divide_error) error_beats++;
            if (got.red_gain !== exp_g.red_gain)
               $display("%0t red_gain expected %0d actual %0d", $time,
                        exp_g.red_gain, got.red_gain);
            if (got.green_gain !== exp_g.green_gain)
               $display("%0t green_gain expected %0d actual %0d", $time,
                        exp_g.green_gain, got.green_gain);
            if (got.blue_gain !== exp_g.blue_gain)
               $display("%0t blue_gain expected %0d actual %0d", $time,
                        exp_g.blue_gain, got.blue_gain);
            if (got.red_write !== exp_g.red_write)
               $display("%0t red_write expected %b actual %b", $time,
                        exp_g.red_write, got.red_write);
            if (got.green_write !== exp_g.green_write)
               $display("%0t green_write expected %b actual %b", $time,
                        exp_g.green_write, got.green_write);
            if (got.blue_write !== exp_g.blue_write)
               $display("%0t blue_write expected %b actual %b", $time,
                        exp_g.blue_write, got.blue_write);
            if (got.divide_error !== exp_g.divide_error)
               $display("%0t divide_error expected %b actual %b", $time,
                        exp_g.divide_error, got.divide_error);
            if (got !== exp_g) errors++;
         end
      end
   end

   // random gap before a beat, mostly short; start drops only for a real gap
   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 9) < 6) ? 0 :
          ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 60);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // send one record; start stays high across back-to-back beats
   task automatic send_record(logic [7:0] rgh, logic [7:0] bgh, logic [7:0] rah,
         logic [7:0] bah, logic [7:0] low, bit gaps);
      if (gaps && $urandom_range(0, 1)) idle_gap();
      req_rg_high_byte <= rgh;
      req_bg_high_byte <= bgh;
      req_rg_adjust_high_byte <= rah;
      req_bg_adjust_high_byte <= bah;
      req_low_bits_byte <= low;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_gains.push_back(compute_gains(rgh, bgh, rah, bah, low));
      records_sent++;
   endtask

   // wait out every expected beat plus the pipeline depth
   task automatic drain();
      int guard;
      guard = 0;
      start <= 1'b0;
      @(posedge clock);
      while (pending_gains.size() != 0 && guard < 10000) begin
         @(posedge clock);
         guard++;
      end
      repeat (wbg_pkg::LATENCY + 5) @(posedge clock);
   endtask

   // one register write; the enable is dropped by the caller
   task automatic write_reg(logic [1:0] idx, logic [9:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      case (idx)
         wbg_pkg::REG_RG_TYPICAL: rg_typ_q = data;
         wbg_pkg::REG_BG_TYPICAL: bg_typ_q = data;
         wbg_pkg::REG_GOLDEN_RG:  golden_rg_q = data[0];
         wbg_pkg::REG_GOLDEN_BG:  golden_bg_q = data[0];
         default: ;
      endcase
   endtask

   task automatic set_config(logic [9:0] rt, logic [9:0] bt, logic gr, logic gb);
      write_reg(wbg_pkg::REG_RG_TYPICAL, rt);
      write_reg(wbg_pkg::REG_BG_TYPICAL, bt);
      write_reg(wbg_pkg::REG_GOLDEN_RG, {9'd0, gr});
      write_reg(wbg_pkg::REG_GOLDEN_BG, {9'd0, gb});
      csr_write_enable <= 1'b0;
   endtask

   // extremes, zero ratios, zero base, saturation, golden scaling
   task automatic test_directed();
      send_record(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 0);
      send_record(8'h00, 8'h40, 8'h00, 8'h00, 8'h00, 0);
      send_record(8'h40, 8'h00, 8'h00, 8'h00, 8'h00, 0);
      send_record(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 0);
      send_record(8'h40, 8'h40, 8'h00, 8'h00, 8'h00, 0);
      send_record(8'h00, 8'hFF, 8'h00, 8'h00, 8'h40, 0);
      send_record(8'hFF, 8'h00, 8'h00, 8'h00, 8'h10, 0);
      send_record(8'h20, 8'h80, 8'h55, 8'hAA, 8'h5A, 0);
      drain();
      // low typical value drives base toward zero
      set_config(10'd1, 10'd1023, 1'b0, 1'b0);
      send_record(8'hFF, 8'h01, 8'h00, 8'h00, 8'hFF, 0);
      send_record(8'h00, 8'hFF, 8'h00, 8'h00, 8'h40, 0);
      send_record(8'h01, 8'h01, 8'h00, 8'h00, 8'h00, 0);
      drain();
      // golden scaling: zero adjust, max adjust, scaled to zero
      set_config(10'd1023, 10'd1, 1'b1, 1'b1);
      send_record(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 0);
      send_record(8'hFF, 8'hFF, 8'h00, 8'h00, 8'hF0, 0);
      send_record(8'h00, 8'h00, 8'h00, 8'h00, 8'h50, 0);
      send_record(8'h00, 8'h10, 8'hFF, 8'hFF, 8'h4F, 0);
      send_record(8'h01, 8'hFF, 8'h80, 8'h00, 8'h00, 0);
      drain();
      // out-of-range zero typical value
      set_config(10'd0, 10'd0, 1'b0, 1'b1);
      send_record(8'h40, 8'h40, 8'h12, 8'h34, 8'h56, 0);
      send_record(8'hFF, 8'h01, 8'hFF, 8'h00, 8'hFF, 0);
      drain();
   endtask

   // random records across several register settings
   task automatic test_random();
      for (int phase = 0; phase < 7; phase++) begin
         case (phase)
            0: set_config(10'd256, 10'd256, 1'b0, 1'b0);
            1: set_config(10'd1023, 10'd1023, 1'b1, 1'b0);
            2: set_config(10'd1, 10'd1, 1'b0, 1'b1);
            default: set_config(10'($urandom_range(1, 1023)), 10'($urandom_range(1, 1023)),
                                1'($urandom), 1'($urandom));
         endcase
         for (int i = 0; i < 100; i++) begin
            logic [7:0] rgh, bgh;
            rgh = 8'($urandom);
            bgh = 8'($urandom);
            // bias toward small ratios now and then for large gains
            if ($urandom_range(0, 7) == 0) rgh = 8'($urandom_range(0, 3));
            if ($urandom_range(0, 7) == 0) bgh = 8'($urandom_range(0, 3));
            send_record(rgh, bgh, 8'($urandom), 8'($urandom), 8'($urandom), phase != 4);
            // sender pause until the pipeline is empty
            if (i == 50 && phase == 3) begin
               start <= 1'b0;
               @(posedge clock);
               while (pending_gains.size() != 0) @(posedge clock);
            end
         end
         drain();
      end
   endtask

   initial begin
      rg_typ_q = 10'd256;
      bg_typ_q = 10'd256;
      golden_rg_q = 1'b0;
      golden_bg_q = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random();
      $display("covered %0d records, %0d beats checked, %0d with divide error",
               records_sent, beats_checked, error_beats);
      if (errors == 0 && pending_gains.size() == 0)
         $display("PASS otp_white_balance_gain_core");
      else
         $display("FAIL otp_white_balance_gain_core");
      $finish;
   end
endmodule
`default_nettype wire

### files.f
+incdir+design
design/wbg_pkg.sv
design/otp_white_balance_gain_core.sv
sim/otp_white_balance_gain_core_test.sv
